@@ hdl/sitda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the integer to decimal text block
// Holds the item type that travels down the binary to BCD pipeline and the
// character codes used by the emitter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned BIN_W        = 32;
    localparam int unsigned DIGITS       = 10;
    localparam int unsigned BCD_W        = DIGITS * 4;
    localparam int unsigned DD_STAGES    = 4;
    localparam int unsigned DD_STEPS     = BIN_W / DD_STAGES;
    localparam int unsigned IDX_W        = 4;

    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [7:0] ASCII_MINUS   = 8'd45;

    // One item in flight through the shift-add-3 pipeline
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } dd_item_t;

endpackage

@@ hdl/sitda_dd_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_dd_stage: one register stage of the binary to BCD converter
// Runs a fixed group of shift-add-3 steps on the item, then registers it.
// Stalls back when its register is full and the next stage does not take it.
// ----------------------------------------------------------------------------
module sitda_dd_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sitda_pkg::dd_item_t in_item,
    output logic                in_ready,
    output logic                out_valid,
    output sitda_pkg::dd_item_t out_item,
    input  logic                out_ready
);

    logic                valid_reg;
    sitda_pkg::dd_item_t item_reg;
    sitda_pkg::dd_item_t item_next;

    // Apply the shift-add-3 steps of this stage
    always_comb
    begin
        logic [sitda_pkg::BCD_W-1:0] b;
        logic [sitda_pkg::BIN_W-1:0] n;
        b = in_item.bcd;
        n = in_item.bin;
        for (int s = 0; s < sitda_pkg::DD_STEPS; s++)
        begin
            for (int d = 0; d < sitda_pkg::DIGITS; d++)
            begin
                if (b[d*4 +: 4] >= 4'd5)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[sitda_pkg::BCD_W-2:0], n[sitda_pkg::BIN_W-1]};
            n = {n[sitda_pkg::BIN_W-2:0], 1'b0};
        end
        item_next.neg = in_item.neg;
        item_next.bcd = b;
        item_next.bin = n;
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage whenever its register is free or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload unless a new item moves in
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ hdl/sitda_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_emit: serial character emitter
// Takes a sign and ten BCD digits, drops leading zeros and sends the text
// one character per cycle while out_stall is low, through a registered output slot.
// ----------------------------------------------------------------------------
module sitda_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_neg,
    input  logic [sitda_pkg::BCD_W-1:0]   in_bcd,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    char_code,
    output logic                          is_last
);

    logic                          busy_reg;
    logic                          neg_pend_reg;
    logic [sitda_pkg::IDX_W-1:0]   idx_reg;
    logic [sitda_pkg::BCD_W-1:0]   bcd_reg;
    logic                          out_valid_reg;
    logic [7:0]                    char_code_reg;
    logic                          is_last_reg;

    logic [sitda_pkg::IDX_W-1:0]   top_idx;
    logic [3:0]                    digit;
    logic                          slot_free;

    // Find the most significant nonzero digit; zero keeps digit 0
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < sitda_pkg::DIGITS; d++)
        begin
            if (in_bcd[d*4 +: 4] != 4'd0)
            begin
                top_idx = sitda_pkg::IDX_W'(d);
            end
        end
    end

    assign digit     = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_ready  = !busy_reg;

    // Load a new item, then advance one character per free output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            neg_pend_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg)
            begin
                if (in_valid)
                begin
                    busy_reg     <= 1'b1;
                    neg_pend_reg <= in_neg;
                    idx_reg      <= top_idx;
                end
                if (slot_free)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (slot_free)
            begin
                out_valid_reg <= 1'b1;
                if (neg_pend_reg)
                begin
                    neg_pend_reg <= 1'b0;
                end
                else if (idx_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
        end
    end

    // Hold digits and output payload
    always_ff @(posedge clk)
    begin
        if (!busy_reg && in_valid)
        begin
            bcd_reg <= in_bcd;
        end
        if (busy_reg && slot_free)
        begin
            if (neg_pend_reg)
            begin
                char_code_reg <= sitda_pkg::ASCII_MINUS;
                is_last_reg   <= 1'b0;
            end
            else
            begin
                char_code_reg <= sitda_pkg::ASCII_ZERO + {4'b0000, digit};
                is_last_reg   <= (idx_reg == '0);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_code_reg;
    assign is_last   = is_last_reg;

endmodule

@@ hdl/signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed integer to decimal ASCII text
// Each input item is one two's complement value; the block sends its decimal
// text one character per output item, a minus sign first for a negative
// value, with is_last on the final character. An input register forms sign
// and magnitude, four register stages of eight shift-add-3 steps each turn
// the magnitude into ten BCD digits, and an emitter sends the characters. An
// item passes through the input register, the BCD stages and the emitter's
// digit register before its first character reaches the output slot. The
// emitter sends one character per cycle while out_stall is low, and takes
// no new item until it has sent the last character of the current one. Up
// to five items queue in the pipeline while the emitter is busy.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sitda_pkg::BIN_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          char_code,
    output logic                                is_last
);

    logic                     in_valid_reg;
    sitda_pkg::dd_item_t      in_item_reg;
    logic                     in_ready;
    logic [sitda_pkg::BIN_W-1:0] mag;

    logic                     stg_valid [sitda_pkg::DD_STAGES+1];
    sitda_pkg::dd_item_t      stg_item  [sitda_pkg::DD_STAGES+1];
    logic                     stg_ready [sitda_pkg::DD_STAGES+1];

    // Form the magnitude; the most negative value wraps to 2^31 unsigned
    assign mag = value[sitda_pkg::BIN_W-1] ? (sitda_pkg::BIN_W'(0) - value) : value;

    assign in_ready = !in_valid_reg || stg_ready[0];
    assign in_stall = !in_ready;

    // Advance the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg.neg <= value[sitda_pkg::BIN_W-1];
            in_item_reg.bcd <= '0;
            in_item_reg.bin <= mag;
        end
    end

    assign stg_valid[0] = in_valid_reg;
    assign stg_item[0]  = in_item_reg;

    // Binary to BCD stages
    for (genvar g = 0; g < sitda_pkg::DD_STAGES; g++)
    begin : g_dd
        sitda_dd_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_item   (stg_item[g]),
            .in_ready  (stg_ready[g]),
            .out_valid (stg_valid[g+1]),
            .out_item  (stg_item[g+1]),
            .out_ready (stg_ready[g+1])
        );
    end

    // Character emitter
    sitda_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[sitda_pkg::DD_STAGES]),
        .in_neg    (stg_item[sitda_pkg::DD_STAGES].neg),
        .in_bcd    (stg_item[sitda_pkg::DD_STAGES].bcd),
        .in_ready  (stg_ready[sitda_pkg::DD_STAGES]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .is_last   (is_last)
    );

endmodule
